FILE: hdl/bounded_integer_set_top_defines.svh
// bounded_integer_set_top_defines.svh: assertion macros for the bounded integer set
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef BOUNDED_INTEGER_SET_TOP_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TOP_DEFINES_SVH

// implication or plain property checked on every clock edge outside reset
`define BIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BIS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: hdl/bis_pkg.sv
// bis_pkg: types and constants shared by the bounded integer set
// no dependencies; imported by the interfaces, the engine and the top level
`default_nettype none

package bis_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned TYPE_W       = 2;
  localparam int unsigned COUNT_OUT_W  = 6;
  localparam int unsigned CAPACITY_DEF = 32;

  typedef enum logic [TYPE_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic                   changed;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] member_count;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/bis_req_if.sv
// bis_req_if: request channel of the bounded integer set (valid/ready plus payload)
// depends on bis_pkg for field widths
`default_nettype none

interface bis_req_if import bis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/bis_rsp_if.sv
// bis_rsp_if: result channel of the bounded integer set (valid/ready plus payload)
// depends on bis_pkg for field widths
`default_nettype none

interface bis_rsp_if import bis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic                   changed;
  logic                   overflow;
  logic [COUNT_OUT_W-1:0] member_count;

  modport source (output valid, output found, output changed, output overflow,
                  output member_count, input ready);
  modport sink   (input valid, input found, input changed, input overflow,
                  input member_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/bounded_integer_set_top.sv
// bounded_integer_set_top: set of distinct 32-bit integers with add, remove, query and clear
// depends on bis_pkg, bis_req_if, bis_rsp_if and bis_engine
`default_nettype none

// One request at a time. A clear, or any request on an empty set, goes straight to the result
// state after acceptance. Otherwise the engine walks the members through the single read port
// of the entry memory, one entry per cycle, comparing each against the value, and a remove keeps
// walking to shift the later entries down. The engine takes no new request until its result
// has moved into the output register. The result sits in an output register, so the next
// request is taken while a result waits to be collected.
module bounded_integer_set_top import bis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bis_req_if.sink    req_i,
  bis_rsp_if.source  rsp_o
);

  req_t req;
  res_t res;
  logic res_valid, res_ready;
  logic eng_ready;

  logic rsp_valid_q, rsp_valid_d;
  res_t rsp_data_q;

  assign req.kind  = kind_e'(req_i.req_type);
  assign req.value = req_i.value;
  assign req_i.ready = eng_ready;

  bis_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (eng_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output slot is free when empty or being emptied this cycle
  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (res_valid && res_ready) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_data_q <= res;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.found        = rsp_data_q.found;
  assign rsp_o.changed      = rsp_data_q.changed;
  assign rsp_o.overflow     = rsp_data_q.overflow;
  assign rsp_o.member_count = rsp_data_q.member_count;

endmodule

`default_nettype wire

FILE: hdl/bis_engine.sv
// bis_engine: entry memory, count and the sequencer that walks it with one comparator
// depends on bis_pkg and bounded_integer_set_top_defines.svh
`default_nettype none
`include "bounded_integer_set_top_defines.svh"

module bis_engine import bis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  kind_e             kind_q, kind_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              found_q, found_d;
  logic              changed_q, changed_d;
  logic              overflow_q, overflow_d;

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic          hit, last;
  logic [CW-1:0] nxt;

  // the shared comparator: entry read last cycle against the request value
  assign hit  = (rd_data_q == value_q);
  assign last = (idx_q == (count_q - ONE));
  assign nxt  = idx_q + ONE;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    kind_d     = kind_q;
    value_d    = value_q;
    found_d    = found_q;
    changed_d  = changed_q;
    overflow_d = overflow_q;
    rd_en      = 1'b0;
    rd_addr    = AW'(nxt);
    wr_en      = 1'b0;
    wr_addr    = AW'(count_q);
    wr_data    = value_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d     = req_i.kind;
          value_d    = $unsigned(req_i.value);
          idx_d      = '0;
          found_d    = 1'b0;
          changed_d  = 1'b0;
          overflow_d = 1'b0;
          if (req_i.kind == KIND_CLEAR) begin
            changed_d = (count_q != '0);
            count_d   = '0;
            state_d   = ST_RESP;
          end else if (count_q == '0) begin
            // empty set: nothing to walk
            if (req_i.kind == KIND_ADD) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = $unsigned(req_i.value);
              count_d   = ONE;
              changed_d = 1'b1;
            end
            state_d = ST_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          found_d = 1'b1;
          if (kind_q == KIND_REMOVE) begin
            changed_d = 1'b1;
            if (last) begin
              count_d = count_q - ONE;
              state_d = ST_RESP;
            end else begin
              rd_en   = 1'b1;
              idx_d   = nxt;
              state_d = ST_SHIFT;
            end
          end else begin
            state_d = ST_RESP;
          end
        end else if (last) begin
          if (kind_q == KIND_ADD) begin
            if (count_q == CAP_CNT) begin
              overflow_d = 1'b1;
            end else begin
              wr_en     = 1'b1;
              count_d   = count_q + ONE;
              changed_d = 1'b1;
            end
          end
          state_d = ST_RESP;
        end else begin
          rd_en = 1'b1;
          idx_d = nxt;
        end
      end

      ST_SHIFT: begin
        // move the entry read last cycle down one place
        wr_en   = 1'b1;
        wr_addr = AW'(idx_q - ONE);
        wr_data = rd_data_q;
        if (last) begin
          count_d = count_q - ONE;
          state_d = ST_RESP;
        end else begin
          rd_en = 1'b1;
          idx_d = nxt;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.found        = found_q;
  assign res_o.changed      = changed_q;
  assign res_o.overflow     = overflow_q;
  assign res_o.member_count = COUNT_OUT_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    kind_q     <= kind_d;
    value_q    <= value_d;
    found_q    <= found_d;
    changed_q  <= changed_d;
    overflow_q <= overflow_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  `BIS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CAP_CNT, "count above capacity")
  `BIS_ASSERT(a_read_in_set, clk_i, rst_ni, rd_en |-> (CW'(rd_addr) < count_q), "read beyond members")
  `BIS_ASSERT(a_shift_on_remove, clk_i, rst_ni, (state_q == ST_SHIFT) |-> (kind_q == KIND_REMOVE && found_q), "shift outside remove hit")
  `BIS_ASSERT(a_overflow_full, clk_i, rst_ni, (res_valid_o && res_o.overflow) |-> (count_q == CAP_CNT && !res_o.changed && !res_o.found), "overflow flagged with room")
  `BIS_ASSERT_NEVER(a_write_in_resp, clk_i, rst_ni, wr_en && (state_q == ST_RESP || $past(state_q) == ST_RESP && state_q == ST_SEARCH), "memory written outside an update")

endmodule

`default_nettype wire
